// ===== design/three_phase_duty_to_compare_top_defines.svh =====
// Assertion macros for the three-phase duty to compare block.
// Used by the port checker; relies on i_clk and i_rst_n in scope.
`ifndef THREE_PHASE_DUTY_TO_COMPARE_TOP_DEFINES_SVH
`define THREE_PHASE_DUTY_TO_COMPARE_TOP_DEFINES_SVH

// overlapping implication, checked out of reset
`define TPDC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpdc: assertion failed");

// property given whole, checked out of reset
`define TPDC_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tpdc: assertion failed");

`endif

// ===== design/tpdc_pkg.sv =====
// Shared types and constants for the three-phase duty to compare block.
// No dependencies.
`default_nettype none

package tpdc_pkg;

    localparam int PERIOD_BITS = 16;
    localparam int DUTY_BITS   = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SUM_BITS    = DUTY_BITS + 1;
    localparam int ACC_BITS    = DUTY_BITS + 4;
    localparam int PROD_BITS   = PERIOD_BITS + ACC_BITS - 1;
    localparam int CLAMP_BITS  = PROD_BITS - FRAC_BITS;
    localparam int NUM_PHASES  = 3;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(27200);

    localparam logic CMD_PLAIN = 1'b0;
    localparam logic CMD_SVM   = 1'b1;

    typedef logic signed [ACC_BITS-1:0] t_duty;

    typedef struct packed {
        logic                        cmd;
        logic                        group;
        logic signed [DUTY_BITS-1:0] offset;
        logic signed [DUTY_BITS-1:0] duty_u;
        logic signed [DUTY_BITS-1:0] duty_v;
        logic signed [DUTY_BITS-1:0] duty_w;
    } t_cmd_item;

    typedef struct packed {
        logic                   target_group;
        logic [PERIOD_BITS-1:0] cmp_u;
        logic [PERIOD_BITS-1:0] cmp_v;
        logic [PERIOD_BITS-1:0] cmp_w;
    } t_cmp_result;

    typedef struct packed {
        logic valid;
        logic group;
    } t_ctl;

endpackage

`default_nettype wire

// ===== design/tpdc_inject.sv =====
// Mode select and min-max injection stage, registered.
// Depends on tpdc_pkg.
`default_nettype none

module tpdc_inject
    import tpdc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctl      i_ctl,
    input  wire t_cmd_item i_item,
    output t_ctl           o_ctl,
    output t_duty          o_duty [NUM_PHASES]
);

    logic signed [DUTY_BITS-1:0] w_d [NUM_PHASES];
    logic signed [SUM_BITS-1:0]  w_s [NUM_PHASES];
    logic signed [SUM_BITS-1:0]  w_max;
    logic signed [SUM_BITS-1:0]  w_min;
    t_duty                       w_off2;
    t_duty                       n_duty [NUM_PHASES];
    t_ctl                        r_ctl;
    t_duty                       r_duty [NUM_PHASES];

    always_comb begin
        w_d[0] = i_item.duty_u;
        w_d[1] = i_item.duty_v;
        w_d[2] = i_item.duty_w;
        for (int i = 0; i < NUM_PHASES; i++) begin
            w_s[i] = SUM_BITS'(w_d[i]) + SUM_BITS'(i_item.offset);
        end
        w_max = w_s[0];
        w_min = w_s[0];
        for (int i = 1; i < NUM_PHASES; i++) begin
            if (w_s[i] > w_max) begin
                w_max = w_s[i];
            end
            if (w_s[i] < w_min) begin
                w_min = w_s[i];
            end
        end
        w_off2 = ACC_BITS'(i_item.offset) <<< 1;
        for (int i = 0; i < NUM_PHASES; i++) begin
            unique case (i_item.cmd)
                CMD_PLAIN: n_duty[i] = ACC_BITS'(w_d[i]) <<< 2;
                CMD_SVM:   n_duty[i] = (ACC_BITS'(w_s[i]) <<< 1) + w_off2
                                       - ACC_BITS'(w_max) - ACC_BITS'(w_min);
                default:   n_duty[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_PHASES; i++) begin
            r_duty[i] <= n_duty[i];
        end
    end

    assign o_ctl = r_ctl;

    always_comb begin
        for (int i = 0; i < NUM_PHASES; i++) begin
            o_duty[i] = r_duty[i];
        end
    end

endmodule

`default_nettype wire

// ===== design/tpdc_lane.sv =====
// One phase lane: period multiply, then truncate and clamp, both registered.
// Depends on tpdc_pkg.
`default_nettype none

module tpdc_lane
    import tpdc_pkg::*;
#(
    parameter int CMP_FLOOR = 48
) (
    input  wire logic                   i_clk,
    input  wire logic [PERIOD_BITS-1:0] i_period,
    input  wire t_duty                  i_duty,
    output logic      [PERIOD_BITS-1:0] o_compare
);

    localparam logic [CLAMP_BITS-1:0] FLOOR_C = CLAMP_BITS'(CMP_FLOOR);

    logic [PROD_BITS-1:0]   n_prod;
    logic [PROD_BITS-1:0]   r_prod;
    logic [CLAMP_BITS-1:0]  w_coarse;
    logic [CLAMP_BITS-1:0]  w_period;
    logic [CLAMP_BITS-1:0]  w_hi;
    logic [CLAMP_BITS-1:0]  w_clamp;
    logic [PERIOD_BITS-1:0] r_cmp;

    // non-positive duty gives zero, which the floor then lifts
    always_comb begin
        if (i_duty > 0) begin
            n_prod = PROD_BITS'(i_period) * PROD_BITS'(i_duty[ACC_BITS-2:0]);
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_comb begin
        w_coarse = r_prod[PROD_BITS-1:FRAC_BITS];
        w_period = CLAMP_BITS'(i_period);
        w_hi     = (w_period > FLOOR_C) ? (w_period - FLOOR_C) : '0;
        w_clamp  = (w_coarse < FLOOR_C) ? FLOOR_C : w_coarse;
        if (w_clamp > w_hi) begin
            w_clamp = w_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp <= PERIOD_BITS'(w_clamp);
    end

    assign o_compare = r_cmp;

endmodule

`default_nettype wire

// ===== design/three_phase_duty_to_compare_top.sv =====
// Three-phase duty to PWM compare converter, top level.
// Depends on tpdc_pkg, tpdc_inject and tpdc_lane.
//
// One transfer is taken on every clock where start is high; busy is always low.
// Each transfer gives one result, strobed on o_valid once it has passed the
// input register, injection stage, multiplier register and clamp register,
// so a new set of duties can go in every cycle. The receiver cannot stall the
// result. The period register is written through i_cfg_we/i_cfg_wdata and must
// only change while no transfer is in flight.
`default_nettype none

module three_phase_duty_to_compare_top
    import tpdc_pkg::*;
#(
    parameter int CMP_FLOOR = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire t_cmd_item              i_item,
    output logic                        o_valid,
    output t_cmp_result                 o_result,
    input  wire logic                   i_cfg_we,
    input  wire logic [PERIOD_BITS-1:0] i_cfg_wdata
);

    logic [PERIOD_BITS-1:0] r_period;
    t_ctl                   r_in_ctl;
    t_cmd_item              r_item;
    t_ctl                   w_inj_ctl;
    t_duty                  w_duty [NUM_PHASES];
    t_ctl                   r_prod_ctl;
    t_ctl                   r_out_ctl;
    logic [PERIOD_BITS-1:0] w_cmp [NUM_PHASES];
    logic                   w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl   <= '0;
            r_prod_ctl <= '0;
            r_out_ctl  <= '0;
        end else begin
            r_in_ctl   <= '{valid: w_accept, group: i_item.group};
            r_prod_ctl <= w_inj_ctl;
            r_out_ctl  <= r_prod_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    tpdc_inject u_inject (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_in_ctl),
        .i_item  (r_item),
        .o_ctl   (w_inj_ctl),
        .o_duty  (w_duty)
    );

    for (genvar g = 0; g < NUM_PHASES; g++) begin : g_lane
        tpdc_lane #(
            .CMP_FLOOR (CMP_FLOOR)
        ) u_lane (
            .i_clk     (i_clk),
            .i_period  (r_period),
            .i_duty    (w_duty[g]),
            .o_compare (w_cmp[g])
        );
    end

    assign o_valid                = r_out_ctl.valid;
    assign o_result.target_group  = r_out_ctl.group;
    assign o_result.cmp_u         = w_cmp[0];
    assign o_result.cmp_v         = w_cmp[1];
    assign o_result.cmp_w         = w_cmp[2];

endmodule

`default_nettype wire

// ===== design/tpdc_checker.sv =====
// Port-level checker for the three-phase duty to compare block, with its bind.
// Depends on tpdc_pkg and three_phase_duty_to_compare_top_defines.svh.
`default_nettype none

`include "three_phase_duty_to_compare_top_defines.svh"

module tpdc_checker
    import tpdc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire t_cmd_item   i_item,
    input wire logic        o_valid,
    input wire t_cmp_result o_result
);

    // every transfer taken gives its result on o_valid
    `TPDC_ASSERT_IMP(a_fwd_latency, start && !busy, ##4 o_valid)
    // no result without an earlier transfer
    `TPDC_ASSERT_IMP(a_no_spurious, o_valid, $past(start && !busy, 4))
    // group follows its transfer through the pipe
    `TPDC_ASSERT_IMP(a_group_carry, o_valid, o_result.target_group == $past(i_item.group, 4))
    // one result per transfer: a lone start gives a lone strobe
    `TPDC_ASSERT_PROP(a_single_strobe, (!start ##1 start ##1 !start) |=> ##2 (o_valid ##1 !o_valid))

endmodule

bind three_phase_duty_to_compare_top tpdc_checker u_tpdc_checker (.*);

`default_nettype wire

// ===== sim/compare_checker.sv =====
`timescale 1ns / 100ps
// Checker for the three-phase duty to compare block: watches the command, result and
// period write channels, predicts each result and compares it with what comes out.
// Depends on tpdc_pkg.

module compare_checker
    import tpdc_pkg::*;
#(
    parameter int CMP_FLOOR = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_cmd_item              i_item,
    input  logic                   i_valid,
    input  t_cmp_result            i_result,
    input  logic                   i_cfg_we,
    input  logic [PERIOD_BITS-1:0] i_cfg_wdata,
    output int                     o_pending,
    output int                     o_fail_count,
    output int                     o_checked
);

    localparam int PROD_W = PERIOD_BITS + ACC_BITS;

    t_cmp_result            expected_compares [$];
    logic [PERIOD_BITS-1:0] period_ticks = PERIOD_RESET;
    int                     fails   = 0;
    int                     checked = 0;

    function automatic logic [PERIOD_BITS-1:0] duty_to_compare(input t_duty d,
                                                               input logic [PERIOD_BITS-1:0] p);
        logic [PROD_W-1:0] pw;
        logic [PROD_W-1:0] dw;
        logic [PROD_W-1:0] hi;
        logic [PROD_W-1:0] c;
        pw = PROD_W'(p);
        dw = PROD_W'(d);
        hi = (pw > PROD_W'(CMP_FLOOR)) ? pw - PROD_W'(CMP_FLOOR) : '0;
        if (d <= 0) begin
            c = '0;
        end else begin
            c = (pw * dw) >> FRAC_BITS;
        end
        if (c < PROD_W'(CMP_FLOOR)) c = PROD_W'(CMP_FLOOR);
        if (c > hi) c = hi;
        return c[PERIOD_BITS-1:0];
    endfunction

    // duties are carried in 2^-16 units so the halving in space-vector mode stays exact
    function automatic t_cmp_result predict_compares(input t_cmd_item it,
                                                     input logic [PERIOD_BITS-1:0] p);
        t_duty       s [NUM_PHASES];
        t_duty       r [NUM_PHASES];
        t_duty       off;
        t_duty       smax;
        t_duty       smin;
        t_cmp_result res;
        off  = it.offset;
        s[0] = it.duty_u;
        s[1] = it.duty_v;
        s[2] = it.duty_w;
        if (it.cmd == CMD_SVM) begin
            for (int i = 0; i < NUM_PHASES; i++) s[i] = s[i] + off;
            smax = s[0];
            smin = s[0];
            for (int i = 1; i < NUM_PHASES; i++) begin
                if (s[i] > smax) smax = s[i];
                if (s[i] < smin) smin = s[i];
            end
            for (int i = 0; i < NUM_PHASES; i++) r[i] = 2 * s[i] + 2 * off - smax - smin;
        end else begin
            for (int i = 0; i < NUM_PHASES; i++) r[i] = s[i] * 4;
        end
        res.target_group = it.group;
        res.cmp_u        = duty_to_compare(r[0], p);
        res.cmp_v        = duty_to_compare(r[1], p);
        res.cmp_w        = duty_to_compare(r[2], p);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t compare_checker: result %0d: %s", $time, checked, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_cmp_result want;
        if (!i_rst_n) begin
            period_ticks = PERIOD_RESET;
            expected_compares.delete();
        end else begin
            if (i_valid) begin
                if (expected_compares.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, cmp_u %0d",
                                              i_result.cmp_u));
                end else begin
                    want = expected_compares.pop_front();
                    if (i_result.target_group !== want.target_group)
                        report_mismatch($sformatf("target_group got %0d expected %0d",
                                                  i_result.target_group, want.target_group));
                    if (i_result.cmp_u !== want.cmp_u)
                        report_mismatch($sformatf("cmp_u got %0d expected %0d",
                                                  i_result.cmp_u, want.cmp_u));
                    if (i_result.cmp_v !== want.cmp_v)
                        report_mismatch($sformatf("cmp_v got %0d expected %0d",
                                                  i_result.cmp_v, want.cmp_v));
                    if (i_result.cmp_w !== want.cmp_w)
                        report_mismatch($sformatf("cmp_w got %0d expected %0d",
                                                  i_result.cmp_w, want.cmp_w));
                    checked++;
                end
            end
            if (i_cfg_we) period_ticks = i_cfg_wdata;
            if (i_start && !i_busy) expected_compares.push_back(predict_compares(i_item, period_ticks));
        end
        o_pending    <= expected_compares.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the three-phase duty to compare testbench: clock, reset, command and period
// stimulus, watchdog and verdict. Depends on tpdc_pkg, the block and compare_checker.

module testbench;
    import tpdc_pkg::*;

    localparam int   CMP_FLOOR    = 48;
    localparam int   LATENCY      = 4;
    localparam int   IDLE_LIMIT   = 2000;
    localparam int   RANDOM_ITEMS = 600;
    localparam int   NUM_SETTINGS = 10;
    localparam int   NUM_FIXED    = 7;
    localparam logic GRP_RECT     = 1'b0;
    localparam logic GRP_INV      = 1'b1;

    localparam logic [PERIOD_BITS-1:0] PERIODS [NUM_FIXED] =
        '{PERIOD_RESET, 16'd48, 16'd65535, 16'd30, 16'd0, 16'd65488, 16'd96};

    typedef logic signed [DUTY_BITS-1:0] t_q14;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_cmd_item              i_item;
    logic                   o_valid;
    t_cmp_result            o_result;
    logic                   i_cfg_we;
    logic [PERIOD_BITS-1:0] i_cfg_wdata;

    int pending;
    int fail_count;
    int checked;
    int sent        = 0;
    int svm_sent    = 0;
    int settings    = 1;
    int idle_cycles = 0;

    three_phase_duty_to_compare_top #(
        .CMP_FLOOR(CMP_FLOOR)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    compare_checker #(
        .CMP_FLOOR(CMP_FLOOR)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_valid     (o_valid),
        .i_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_fail_count(fail_count),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("** three_phase_duty_to_compare_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_cmd_item make_item(input logic cmd, input logic grp, input t_q14 off,
                                            input t_q14 u, input t_q14 v, input t_q14 w);
        t_cmd_item it;
        it.cmd    = cmd;
        it.group  = grp;
        it.offset = off;
        it.duty_u = u;
        it.duty_v = v;
        it.duty_w = w;
        return it;
    endfunction

    function automatic t_q14 random_duty();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 6))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                3:       return 16'sh4000;
                4:       return -16'sh4000;
                5:       return 16'sh0001;
                default: return -16'sh0001;
            endcase
        end else if (pick < 4) begin
            return t_q14'($urandom);
        end
        return t_q14'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_item(input t_cmd_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if (it.cmd == CMD_SVM) svm_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    // mostly balanced three-phase sets with random content, the rest raw noise
    task automatic run_random(input int count, input bit no_gaps);
        t_cmd_item it;
        int        u;
        int        v;
        int        gap;
        for (int n = 0; n < count; n++) begin
            it.cmd   = $urandom_range(0, 1) ? CMD_SVM : CMD_PLAIN;
            it.group = $urandom_range(0, 1) ? GRP_INV : GRP_RECT;
            case ($urandom_range(0, 3))
                0:       it.offset = 16'sh2000;
                1:       it.offset = 16'sh0000;
                default: it.offset = random_duty();
            endcase
            if ($urandom_range(0, 9) < 6) begin
                u         = int'($urandom_range(0, 24000)) - 12000;
                v         = int'($urandom_range(0, 24000)) - 12000;
                it.duty_u = t_q14'(u);
                it.duty_v = t_q14'(v);
                it.duty_w = t_q14'(-(u + v));
            end else begin
                it.duty_u = random_duty();
                it.duty_v = random_duty();
                it.duty_w = random_duty();
            end
            send_item(it);
            if (!no_gaps) begin
                case ($urandom_range(0, 49))
                    0:                 gap = $urandom_range(20, 60);
                    1, 2, 3, 4:        gap = $urandom_range(4, 12);
                    5:                 gap = -1;
                    default:           gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                endcase
                if (gap < 0) begin
                    drain();
                end else if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(make_item(CMD_PLAIN, GRP_RECT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
        send_item(make_item(CMD_PLAIN, GRP_INV, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_item(make_item(CMD_PLAIN, GRP_RECT, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000));
        send_item(make_item(CMD_PLAIN, GRP_INV, 16'sh0000, 16'sh4000, 16'sh2000, -16'sh2000));
        send_item(make_item(CMD_PLAIN, GRP_RECT, 16'sh1234, 16'sh0001, 16'sh0002, 16'sh0004));
        send_item(make_item(CMD_PLAIN, GRP_INV, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000));
        send_item(make_item(CMD_PLAIN, GRP_RECT, 16'sh0000, 16'sh3FFF, 16'sh4001, -16'sh0001));
        send_item(make_item(CMD_SVM, GRP_RECT, 16'sh0000, 16'sh2000, -16'sh1000, -16'sh1000));
        send_item(make_item(CMD_SVM, GRP_INV, 16'sh2000, 16'sh376D, -16'sh1BB6, -16'sh1BB7));
        send_item(make_item(CMD_SVM, GRP_RECT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_item(make_item(CMD_SVM, GRP_INV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        send_item(make_item(CMD_SVM, GRP_RECT, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000));
        send_item(make_item(CMD_SVM, GRP_INV, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_item(make_item(CMD_SVM, GRP_RECT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
        send_item(make_item(CMD_SVM, GRP_INV, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000));
        send_item(make_item(CMD_SVM, GRP_RECT, -16'sh4000, 16'sh4000, -16'sh4000, 16'sh0001));

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            if (k > 0) begin
                drain();
                write_period(k < NUM_FIXED ? PERIODS[k] : 16'($urandom_range(48, 65488)));
            end
            run_random(RANDOM_ITEMS / NUM_SETTINGS, k % 2 == 1);
        end
        drain();

        $display("covered %0d command transfers (%0d space-vector) over %0d period settings,",
                 sent, svm_sent, settings);
        $display("including periods at and below the compare floor; %0d results compared",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** three_phase_duty_to_compare_top: PASSED **");
        end else begin
            $display("** three_phase_duty_to_compare_top: FAILED **");
        end
        $finish;
    end

endmodule
